### rtl/core/gdc_pkg.sv
// Shared constants and a helper function for the go-to-goal drive controller.
// Holds register indexes, angle constants, the CORDIC arctangent table and the divider constants.
// No dependencies.
package gdc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_MAX_STAGES = 24;

  // Width of the CORDIC x/y datapath, enough for a 33-bit offset after gain growth.
  localparam int CW = 36;

  // Configuration register indexes.
  localparam logic [2:0] REG_DIST_TOL  = 3'd0;
  localparam logic [2:0] REG_ANG_TOL   = 3'd1;
  localparam logic [2:0] REG_TURN_GAIN = 3'd2;
  localparam logic [2:0] REG_SPD_GAIN  = 3'd3;
  localparam logic [2:0] REG_MAX_LIN   = 3'd4;
  localparam logic [2:0] REG_MAX_TURN  = 3'd5;

  // Register reset values.
  localparam logic [30:0] DIST_TOL_RST  = 31'd32768;
  localparam logic [14:0] ANG_TOL_RST   = 15'd2859;
  localparam logic [15:0] TURN_GAIN_RST = 16'd16384;
  localparam logic [15:0] SPD_GAIN_RST  = 16'd16384;
  localparam logic [14:0] MAX_LIN_RST   = 15'd4096;
  localparam logic [14:0] MAX_TURN_RST  = 15'd4096;

  localparam logic signed [31:0] PI_Q28_Z  = 32'sd843314857;
  localparam logic signed [33:0] PI_Q28    = 34'sd843314857;
  localparam logic signed [33:0] TWO_PI_Q28 = 34'sd1686629714;
  localparam logic [14:0]        PI_Q13    = 15'd25736;

  // Floor division by pi in Q13 through a reciprocal; exact for dividends below 2^30.
  localparam int            DIV_SHIFT = 45;
  localparam longint        DIV_D     = 64'd25736;
  localparam longint        DIV_M_L   = ((64'd1 << DIV_SHIFT) + DIV_D - 64'd1) / DIV_D;
  localparam logic [30:0]   DIV_M     = 31'(DIV_M_L);

  // Arctangent of 2^-i in Q3.28.
  function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4193963;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/go_to_goal_drive_controller.sv
// Go-to-goal drive controller: distance, bearing error and speed commands per control tick.
// Pipelined square root, two vectoring CORDICs and a multiply/divide tail.
// Depends on gdc_pkg.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         tvalid/tready             tdata: target, position, heading
//  m_axis    out        tvalid/tready             tdata: speeds, tuser: status flags
//  cfg       in         cfg_we (no wait)          cfg_index, cfg_data
//
// One item enters per cycle while the pipeline is not stalled by a full, unread output register.
// The depth is set by the 32 stages of the digit-by-digit square root; the CORDICs
// (CORDIC_STAGES deep) run beside it and their angle error waits in a delay line.
// The whole pipeline advances when the output register is empty or being read.
// Reset is synchronous, clears the valid bits and loads the configuration registers with their reset values.
module go_to_goal_drive_controller #(
  parameter int CORDIC_STAGES = gdc_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // goal_x, goal_y, position_x, position_y, heading_x, heading_y
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // linear_speed, turn_rate, one zero pad bit
  output logic [31:0]  m_axis_tdata,
  // arrived, turning_in_place
  output logic [1:0]   m_axis_tuser
);

  localparam int CS   = CORDIC_STAGES;
  localparam int CW   = gdc_pkg::CW;
  localparam int LAST = 40;
  localparam int DLY  = 32 - CS;

  // Configuration registers.
  logic [30:0] dist_tol;
  logic [14:0] ang_tol;
  logic [15:0] turn_gain;
  logic [15:0] spd_gain;
  logic [14:0] max_lin;
  logic [14:0] max_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_tol  <= gdc_pkg::DIST_TOL_RST;
      ang_tol   <= gdc_pkg::ANG_TOL_RST;
      turn_gain <= gdc_pkg::TURN_GAIN_RST;
      spd_gain  <= gdc_pkg::SPD_GAIN_RST;
      max_lin   <= gdc_pkg::MAX_LIN_RST;
      max_turn  <= gdc_pkg::MAX_TURN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gdc_pkg::REG_DIST_TOL:  dist_tol  <= cfg_data;
        gdc_pkg::REG_ANG_TOL:   ang_tol   <= cfg_data[14:0];
        gdc_pkg::REG_TURN_GAIN: turn_gain <= cfg_data[15:0];
        gdc_pkg::REG_SPD_GAIN:  spd_gain  <= cfg_data[15:0];
        gdc_pkg::REG_MAX_LIN:   max_lin   <= cfg_data[14:0];
        gdc_pkg::REG_MAX_TURN:  max_turn  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves when the output register is free or read.
  logic            en;
  logic [LAST:0]   vld;

  assign en            = !vld[LAST] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], s_axis_tvalid};
    end
  end

  // Stage 0: input capture.
  logic signed [31:0] tgt_x0, tgt_y0, pos_x0, pos_y0;
  logic signed [15:0] hd_x0, hd_y0;
  // Stage 1: offsets to the goal.
  logic signed [32:0] dx1, dy1;
  logic signed [15:0] hd_x1, hd_y1;
  // Stage 2..3: magnitudes and squares.
  logic [30:0] ax2, ay2;
  logic        far2, far3;
  logic [61:0] sq_x3, sq_y3;

  always_ff @(posedge clk) begin
    if (en) begin
      tgt_x0 <= s_axis_tdata[31:0];
      tgt_y0 <= s_axis_tdata[63:32];
      pos_x0 <= s_axis_tdata[95:64];
      pos_y0 <= s_axis_tdata[127:96];
      hd_x0  <= s_axis_tdata[143:128];
      hd_y0  <= s_axis_tdata[159:144];
      dx1    <= 33'(tgt_x0) - 33'(pos_x0);
      dy1    <= 33'(tgt_y0) - 33'(pos_y0);
      hd_x1  <= hd_x0;
      hd_y1  <= hd_y0;
      ax2    <= dx1[32] ? 31'(-dx1) : dx1[30:0];
      ay2    <= dy1[32] ? 31'(-dy1) : dy1[30:0];
      // A magnitude of 2^31 or more saturates the distance.
      far2   <= (dx1 >= 33'sd2147483648) || (dx1 <= -33'sd2147483648) ||
                (dy1 >= 33'sd2147483648) || (dy1 <= -33'sd2147483648);
      sq_x3  <= ax2 * ax2;
      sq_y3  <= ay2 * ay2;
      far3   <= far2;
    end
  end

  // Square root, one result bit per stage; index 0 is stage 4.
  logic [63:0] sr_n    [0:32];
  logic [34:0] sr_rem  [0:32];
  logic [31:0] sr_root [0:32];
  logic        sr_far  [0:32];
  logic [34:0] sr_rem_next  [0:31];
  logic [31:0] sr_root_next [0:31];

  always_comb begin
    logic [34:0] rem_sh;
    logic [34:0] trial;
    for (int k = 0; k < 32; k++) begin
      rem_sh = {sr_rem[k][32:0], sr_n[k][63:62]};
      trial  = {1'b0, sr_root[k], 2'b01};
      if (rem_sh >= trial) begin
        sr_rem_next[k]  = rem_sh - trial;
        sr_root_next[k] = {sr_root[k][30:0], 1'b1};
      end else begin
        sr_rem_next[k]  = rem_sh;
        sr_root_next[k] = {sr_root[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_n[0]    <= 64'(sq_x3) + 64'(sq_y3);
      sr_rem[0]  <= '0;
      sr_root[0] <= '0;
      sr_far[0]  <= far3;
      for (int k = 0; k < 32; k++) begin
        sr_n[k+1]    <= {sr_n[k][61:0], 2'b00};
        sr_rem[k+1]  <= sr_rem_next[k];
        sr_root[k+1] <= sr_root_next[k];
        sr_far[k+1]  <= sr_far[k];
      end
    end
  end

  // Vectoring CORDICs for the goal bearing (ct_) and the heading (ch_); index 0 is stage 2.
  logic signed [CW-1:0] ct_x [0:CS];
  logic signed [CW-1:0] ct_y [0:CS];
  logic signed [31:0]   ct_z [0:CS];
  logic                 ct_zero [0:CS];
  logic signed [CW-1:0] ch_x [0:CS];
  logic signed [CW-1:0] ch_y [0:CS];
  logic signed [31:0]   ch_z [0:CS];
  logic                 ch_zero [0:CS];
  logic signed [CW-1:0] ct_x_next [0:CS-1];
  logic signed [CW-1:0] ct_y_next [0:CS-1];
  logic signed [31:0]   ct_z_next [0:CS-1];
  logic signed [CW-1:0] ch_x_next [0:CS-1];
  logic signed [CW-1:0] ch_y_next [0:CS-1];
  logic signed [31:0]   ch_z_next [0:CS-1];

  always_comb begin
    logic signed [CW-1:0] tx, ty, hx, hy;
    logic signed [31:0]   at;
    for (int i = 0; i < CS; i++) begin
      at = gdc_pkg::atan_q28(5'(i));
      tx = ct_x[i] >>> i;
      ty = ct_y[i] >>> i;
      if (ct_y[i] > 0) begin
        ct_x_next[i] = ct_x[i] + ty;
        ct_y_next[i] = ct_y[i] - tx;
        ct_z_next[i] = ct_z[i] + at;
      end else begin
        ct_x_next[i] = ct_x[i] - ty;
        ct_y_next[i] = ct_y[i] + tx;
        ct_z_next[i] = ct_z[i] - at;
      end
      hx = ch_x[i] >>> i;
      hy = ch_y[i] >>> i;
      if (ch_y[i] > 0) begin
        ch_x_next[i] = ch_x[i] + hy;
        ch_y_next[i] = ch_y[i] - hx;
        ch_z_next[i] = ch_z[i] + at;
      end else begin
        ch_x_next[i] = ch_x[i] - hy;
        ch_y_next[i] = ch_y[i] + hx;
        ch_z_next[i] = ch_z[i] - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Vectors in the left half plane are rotated by pi before the iterations.
      ct_zero[0] <= (dx1 == '0) && (dy1 == '0);
      if (dx1 < 0) begin
        ct_x[0] <= -CW'(dx1);
        ct_y[0] <= -CW'(dy1);
        ct_z[0] <= (dy1 >= 0) ? gdc_pkg::PI_Q28_Z : -gdc_pkg::PI_Q28_Z;
      end else begin
        ct_x[0] <= CW'(dx1);
        ct_y[0] <= CW'(dy1);
        ct_z[0] <= '0;
      end
      ch_zero[0] <= (hd_x1 == '0) && (hd_y1 == '0);
      if (hd_x1 < 0) begin
        ch_x[0] <= -CW'(hd_x1);
        ch_y[0] <= -CW'(hd_y1);
        ch_z[0] <= (hd_y1 >= 0) ? gdc_pkg::PI_Q28_Z : -gdc_pkg::PI_Q28_Z;
      end else begin
        ch_x[0] <= CW'(hd_x1);
        ch_y[0] <= CW'(hd_y1);
        ch_z[0] <= '0;
      end
      for (int i = 0; i < CS; i++) begin
        ct_x[i+1]    <= ct_x_next[i];
        ct_y[i+1]    <= ct_y_next[i];
        ct_z[i+1]    <= ct_z_next[i];
        ct_zero[i+1] <= ct_zero[i];
        ch_x[i+1]    <= ch_x_next[i];
        ch_y[i+1]    <= ch_y_next[i];
        ch_z[i+1]    <= ch_z_next[i];
        ch_zero[i+1] <= ch_zero[i];
      end
    end
  end

  // Heading error: difference, wrap into [-pi, pi], round to Q13 and clamp.
  logic signed [33:0] diff_raw, diff_wrap, diff_r, err_rnd;
  logic signed [15:0] err_val;
  logic signed [15:0] err_dly [0:DLY];

  always_comb begin
    diff_raw = (ct_zero[CS] ? 34'sd0 : 34'(ct_z[CS])) -
               (ch_zero[CS] ? 34'sd0 : 34'(ch_z[CS]));
    if (diff_raw > gdc_pkg::PI_Q28) begin
      diff_wrap = diff_raw - gdc_pkg::TWO_PI_Q28;
    end else if (diff_raw < -gdc_pkg::PI_Q28) begin
      diff_wrap = diff_raw + gdc_pkg::TWO_PI_Q28;
    end else begin
      diff_wrap = diff_raw;
    end
    err_rnd = (diff_r + 34'sd16384) >>> 15;
    if (err_rnd > 34'sd25736) begin
      err_val = 16'sd25736;
    end else if (err_rnd < -34'sd25736) begin
      err_val = -16'sd25736;
    end else begin
      err_val = 16'(err_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r     <= diff_wrap;
      err_dly[0] <= err_val;
      for (int k = 0; k < DLY; k++) begin
        err_dly[k+1] <= err_dly[k];
      end
    end
  end

  // Tail: distance and error are aligned at stage 36.
  logic [31:0]        dist36;
  logic signed [15:0] err36;

  assign dist36 = sr_far[32] ? '1 : sr_root[32];
  assign err36  = err_dly[DLY];

  logic               arr37, arr38, arr39;
  logic [14:0]        aerr37, aerr38;
  logic signed [32:0] tprod37;
  logic [47:0]        lprod37;
  logic signed [17:0] turn38;
  logic [14:0]        lin38;
  logic               turning38, turning39;
  logic [29:0]        p39;
  logic signed [15:0] turn39;
  logic signed [32:0] turn_rnd;
  logic signed [17:0] max_turn_s;
  logic signed [15:0] turn_sel;
  logic [60:0]        q_prod;

  always_comb begin
    turn_rnd   = (tprod37 + 33'sd16384) >>> 15;
    max_turn_s = 18'(max_turn);
    if (arr38) begin
      turn_sel = '0;
    end else if (turning38) begin
      if (turn38 > 18'sd32767) begin
        turn_sel = 16'sd32767;
      end else if (turn38 < -18'sd32768) begin
        turn_sel = -16'sd32768;
      end else begin
        turn_sel = 16'(turn38);
      end
    end else if (turn38 > max_turn_s) begin
      turn_sel = 16'(max_turn_s);
    end else if (turn38 < -max_turn_s) begin
      turn_sel = 16'(-max_turn_s);
    end else begin
      turn_sel = 16'(turn38);
    end
    q_prod = 61'(p39) * 61'(gdc_pkg::DIV_M);
  end

  logic [14:0]        lin_out;
  logic signed [15:0] turn_out;
  logic               arr_out, turning_out;

  always_ff @(posedge clk) begin
    if (en) begin
      arr37     <= dist36 < {1'b0, dist_tol};
      aerr37    <= err36[15] ? 15'(-err36) : err36[14:0];
      tprod37   <= 33'(signed'({1'b0, turn_gain})) * 33'(err36);
      lprod37   <= 48'(spd_gain) * 48'(dist36);

      arr38     <= arr37;
      aerr38    <= aerr37;
      turn38    <= 18'(turn_rnd);
      turning38 <= aerr37 > ang_tol;
      lin38     <= (lprod37[47:18] > 30'(max_lin)) ? max_lin : lprod37[32:18];

      arr39     <= arr38;
      turning39 <= !arr38 && turning38;
      turn39    <= turn_sel;
      p39       <= 30'(lin38) * 30'(gdc_pkg::PI_Q13 - aerr38);

      arr_out     <= arr39;
      turning_out <= turning39;
      turn_out    <= turn39;
      lin_out     <= (arr39 || turning39) ? '0 : 15'(q_prod >> gdc_pkg::DIV_SHIFT);
    end
  end

  assign m_axis_tdata = {1'b0, turn_out, lin_out};
  assign m_axis_tuser = {turning_out, arr_out};

  a_arrived_stops: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && arr_out |-> lin_out == '0 && turn_out == '0 && !turning_out)
    else $error("arrived result carries a nonzero command");

  a_turn_no_drive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && turning_out |-> lin_out == '0)
    else $error("turning in place with forward speed");

  a_lin_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !cfg_we && !$past(cfg_we) |-> lin_out <= max_lin)
    else $error("linear speed above its limit");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld) && $stable(err_dly[0]) && $stable(sr_root[32]))
    else $error("pipeline moved during a stall");

endmodule
